@@ rtl/ttwcd_pkg.sv @@
// Shared types, constants and helpers of the two-tone whistle command detector.
`default_nettype none
package ttwcd_pkg;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF    = 48;
    localparam int COUNT_WIDTH_DEF  = 8;
    localparam int CFG_IDX_WIDTH    = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_TONE1_COEFF  = 3'd0,
        REG_TONE2_COEFF  = 3'd1,
        REG_THRESHOLD    = 3'd2,
        REG_RISE_COUNT   = 3'd3,
        REG_FALL_COUNT   = 3'd4,
        REG_HOLD_COUNT   = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } t_event;

    typedef struct packed {
        logic       tone2_present;
        logic       tone1_present;
        logic [1:0] event_res;
    } t_result;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // saturate a 128-bit value to signed 64 bits
    function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
        logic signed [63:0] r;
        if (v > 128'sd9223372036854775807) r = S64_MAX;
        else if (v < -128'sd9223372036854775808) r = S64_MIN;
        else r = v[63:0];
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/ttwcd_mul.sv @@
// Shared signed multiplier: 64x64 product built from four 32x32 partial products.
`default_nettype none
module ttwcd_mul
    import ttwcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [63:0]   i_a,
    input  wire logic signed [63:0]   i_b,
    output logic                      o_done,
    output logic signed [127:0]       o_p
);
    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [1:0]   r_step;
    logic         r_busy;
    logic [127:0] r_acc;
    logic [63:0]  w_pp;
    logic [31:0]  w_x, w_y;
    logic [127:0] w_sh;
    logic [127:0] w_sum;

    always_comb begin
        w_x   = r_step[0] ? r_ua[63:32] : r_ua[31:0];
        w_y   = r_step[1] ? r_ub[63:32] : r_ub[31:0];
        w_pp  = 64'(w_x) * 64'(w_y);
        w_sh  = 128'(w_pp) << (7'(r_step[0]) * 7'd32 + 7'(r_step[1]) * 7'd32);
        w_sum = r_acc + w_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_ua   <= i_a[63] ? 64'(-i_a) : i_a;
                r_ub   <= i_b[63] ? 64'(-i_b) : i_b;
                r_neg  <= i_a[63] ^ i_b[63];
                r_acc  <= '0;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc  <= w_sum;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_p = r_neg ? -$signed(r_acc) : $signed(r_acc);
endmodule
`default_nettype wire

@@ rtl/two_tone_whistle_command_detector_core.sv @@
// Top level of the two-tone whistle command detector.
// Samples enter on the s_axis group: tdata holds the Q1.15 sample, tlast closes a window.
// Each sample runs both Goertzel recurrences through one shared 64x64 multiplier
// (four 32x32 partial products per product, one product per tone), so s_axis_tready
// stays low after a transfer at least until both recurrences are updated.
// A window-closing sample then computes four more products per tone for the
// energies, updates the debouncers and the sequence machine and places one result in
// the m_axis output register; ready returns with it.
// Other samples give no result.
// A result waits in the output register until taken while the next window goes on;
// that window parks before its result while the register is still full, which holds
// s_axis_tready low until the receiver takes the waiting transfer.
// Configuration writes on the cfg channel are always accepted;
// they are intended while the block is idle.
// Reset (synchronous, active low) clears recurrences, debouncers, the sequence
// machine and restores register defaults.
// m_axis_tdata bits: [1:0] event_res, [2] tone1_present, [3] tone2_present.
`default_nettype none
module two_tone_whistle_command_detector_core
    import ttwcd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // [SW-1:0] sample
    input  wire logic                     s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [7:0]                    m_axis_tdata, // event_res, tone1, tone2
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [63:0]              i_cfg_data
);
    localparam logic signed [63:0] ACC_MAX = 64'((64'sd1 <<< (ACC_WIDTH-1)) - 1);
    localparam logic signed [63:0] ACC_MIN = -ACC_MAX - 64'sd1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_REC_MUL, S_REC_UPD, S_E_T, S_E_Q1Q1, S_E_Q2Q2, S_E_Q1T,
        S_E_FIN, S_SEQ, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE, PH_WAIT1, PH_WAIT2, PH_HOLD
    } t_phase;

    t_state r_state;
    logic signed [63:0] r_q1 [2];
    logic signed [63:0] r_q2 [2];
    logic               r_tone;
    logic               r_last;
    logic signed [63:0] r_x;
    logic signed [15:0] r_c1, r_c2;
    logic [62:0]        r_thr;
    logic [7:0]         r_rise, r_fall, r_hold;
    logic signed [63:0] r_t;
    logic signed [127:0] r_s;
    logic               r_pres [2];
    logic               r_act [2];
    logic [COUNT_WIDTH-1:0] r_cnt [2];
    t_phase             r_phase;
    logic [8:0]         r_persist;
    logic [9:0]         r_gap;
    t_result            r_res;
    logic               r_mstart;
    logic signed [63:0] r_ma, r_mb;

    logic               w_mdone;
    logic signed [127:0] w_mp;
    logic signed [127:0] w_q14;
    logic signed [63:0] w_mq14;
    logic signed [63:0] w_q0;
    logic signed [127:0] w_e;
    logic signed [63:0] w_en;
    logic               w_hit;

    ttwcd_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_mstart),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_done (w_mdone),
        .o_p    (w_mp)
    );

    always_comb begin
        w_q14  = w_mp >>> 14;
        w_mq14 = sat64(w_q14);
        w_q0   = sat64(128'(w_mq14) - 128'(r_q2[r_tone]) + 128'(r_x));
        w_e    = (r_s - w_mp) >>> 30;
        w_en   = sat64(w_e);
        w_hit  = !w_en[63] && (w_en[62:0] > r_thr);
    end

    // debouncer step
    function automatic logic [COUNT_WIDTH:0] deb(input logic act, input logic pres,
                                                 input logic [COUNT_WIDTH-1:0] cnt,
                                                 input logic [7:0] rise,
                                                 input logic [7:0] fall);
        logic [COUNT_WIDTH-1:0] c;
        logic a;
        logic [15:0] tgt;
        a   = act;
        c   = cnt;
        tgt = 16'(act ? fall : rise);
        if (act ? !pres : pres) begin
            if (c != CNT_MAX) c = c + 1'b1;
            if (16'(c) >= tgt) begin
                a = !a;
                c = '0;
            end
        end else if (c != '0) begin
            c = c - 1'b1;
        end
        return {a, c};
    endfunction

    logic [COUNT_WIDTH:0] w_d0, w_d1;
    logic w_p0, w_p1, w_f0, w_f1;
    always_comb begin
        w_p0 = r_pres[0] && !r_pres[1];
        w_p1 = r_pres[1] && !r_pres[0];
        w_d0 = deb(r_act[0], w_p0, r_cnt[0], r_rise, r_fall);
        w_d1 = deb(r_act[1], w_p1, r_cnt[1], r_rise, r_fall);
        w_f0 = w_p1 ? 1'b0 : 1'b1;
        w_f1 = w_p0 ? 1'b0 : 1'b1;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {4'd0, r_res.tone2_present, r_res.tone1_present, r_res.event_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_q1      <= '{default: '0};
            r_q2      <= '{default: '0};
            r_act     <= '{default: 1'b0};
            r_cnt     <= '{default: '0};
            r_phase   <= PH_IDLE;
            r_persist <= '0;
            r_gap     <= '0;
            r_c1      <= '0;
            r_c2      <= '0;
            r_thr     <= 63'd1073741824;
            r_rise    <= 8'd5;
            r_fall    <= 8'd8;
            r_hold    <= 8'd10;
            r_mstart  <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) m_axis_tvalid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TONE1_COEFF: r_c1   <= i_cfg_data[15:0];
                    REG_TONE2_COEFF: r_c2   <= i_cfg_data[15:0];
                    REG_THRESHOLD:   r_thr  <= i_cfg_data[62:0];
                    REG_RISE_COUNT:  r_rise <= i_cfg_data[7:0];
                    REG_FALL_COUNT:  r_fall <= i_cfg_data[7:0];
                    REG_HOLD_COUNT:  r_hold <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_x      <= 64'(signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]));
                        r_last   <= s_axis_tlast;
                        r_tone   <= 1'b0;
                        r_ma     <= r_q1[0];
                        r_mb     <= 64'(r_c1);
                        r_mstart <= 1'b1;
                        r_state  <= S_REC_MUL;
                    end
                end
                S_REC_MUL: begin
                    if (w_mdone) begin
                        r_q2[r_tone] <= r_q1[r_tone];
                        r_q1[r_tone] <= (w_q0 > ACC_MAX) ? ACC_MAX :
                                        (w_q0 < ACC_MIN) ? ACC_MIN : w_q0;
                        r_state <= S_REC_UPD;
                    end
                end
                S_REC_UPD: begin
                    if (!r_tone) begin
                        r_tone   <= 1'b1;
                        r_ma     <= r_q1[1];
                        r_mb     <= 64'(r_c2);
                        r_mstart <= 1'b1;
                        r_state  <= S_REC_MUL;
                    end else if (r_last) begin
                        r_tone   <= 1'b0;
                        r_ma     <= r_q2[0];
                        r_mb     <= 64'(r_c1);
                        r_mstart <= 1'b1;
                        r_state  <= S_E_T;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_E_T: begin
                    if (w_mdone) begin
                        r_t      <= w_mq14;
                        r_ma     <= r_q1[r_tone];
                        r_mb     <= r_q1[r_tone];
                        r_mstart <= 1'b1;
                        r_state  <= S_E_Q1Q1;
                    end
                end
                S_E_Q1Q1: begin
                    if (w_mdone) begin
                        r_s      <= w_mp;
                        r_ma     <= r_q2[r_tone];
                        r_mb     <= r_q2[r_tone];
                        r_mstart <= 1'b1;
                        r_state  <= S_E_Q2Q2;
                    end
                end
                S_E_Q2Q2: begin
                    if (w_mdone) begin
                        r_s      <= r_s + w_mp;
                        r_ma     <= r_q1[r_tone];
                        r_mb     <= r_t;
                        r_mstart <= 1'b1;
                        r_state  <= S_E_Q1T;
                    end
                end
                S_E_Q1T: begin
                    if (w_mdone) begin
                        r_pres[r_tone] <= w_hit;
                        r_q1[r_tone]   <= '0;
                        r_q2[r_tone]   <= '0;
                        r_state        <= S_E_FIN;
                    end
                end
                S_E_FIN: begin
                    if (!r_tone) begin
                        r_tone   <= 1'b1;
                        r_ma     <= r_q2[1];
                        r_mb     <= 64'(r_c2);
                        r_mstart <= 1'b1;
                        r_state  <= S_E_T;
                    end else begin
                        r_state <= S_SEQ;
                    end
                end
                S_SEQ: begin
                    if (w_p0 || w_f0) {r_act[0], r_cnt[0]} <= w_d0;
                    if (w_p1 || w_f1) {r_act[1], r_cnt[1]} <= w_d1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold here while the previous result still waits
                    if (!m_axis_tvalid || m_axis_tready) begin
                        r_res.event_res     <= EV_NONE;
                        r_res.tone1_present <= r_pres[0];
                        r_res.tone2_present <= r_pres[1];
                        case (r_phase)
                            PH_IDLE: begin
                                if (r_act[0] || r_act[1]) begin
                                    if (9'(r_persist + 9'd1) > 9'(r_hold)) begin
                                        r_persist <= '0;
                                        r_phase   <= r_act[0] ? PH_WAIT2 : PH_WAIT1;
                                    end else begin
                                        r_persist <= r_persist + 9'd1;
                                    end
                                end else begin
                                    r_persist <= '0;
                                end
                            end
                            PH_WAIT1, PH_WAIT2: begin
                                if (r_act[r_phase == PH_WAIT2]) begin
                                    if (9'(r_persist + 9'd1) > 9'(r_hold)) begin
                                        r_persist <= '0;
                                        r_gap     <= '0;
                                        r_res.event_res <= (r_phase == PH_WAIT1) ?
                                                           EV_OFF : EV_ON;
                                        r_phase   <= PH_HOLD;
                                    end else begin
                                        r_persist <= r_persist + 9'd1;
                                    end
                                end else if (11'(r_gap + 10'd1) >= 11'(r_hold) * 11'd4) begin
                                    r_persist <= '0;
                                    r_gap     <= '0;
                                    r_phase   <= PH_IDLE;
                                end else begin
                                    r_gap <= r_gap + 10'd1;
                                end
                            end
                            default: begin
                                if (11'(r_gap + 10'd1) >= 11'(r_hold) * 11'd2) begin
                                    r_gap   <= '0;
                                    r_phase <= PH_IDLE;
                                end else begin
                                    r_gap <= r_gap + 10'd1;
                                end
                            end
                        endcase
                        m_axis_tvalid <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/ttwcd_checker.sv @@
// Port-level checks of the two-tone whistle command detector, bound to the top level.
`default_nettype none
module ttwcd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad event code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:4] == 4'd0) else $error("padding set");
endmodule

bind two_tone_whistle_command_detector_core ttwcd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
